[hdl/hfs_pkg.sv]
// shared constants, register indexes, item modes and arithmetic helpers for
// the explicit heat-equation stepper; no dependencies
package hfs_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int GAIN_FRAC     = 16;

    localparam int NODE_W  = 5;
    localparam int TEMP_W  = 32;
    localparam int GAIN_W  = 18;
    localparam int DEG_W   = 16;
    localparam int STEP_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_TEMP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TEMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TEMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT   = 3'd5;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;
    localparam logic [1:0] MODE_HOLD = 2'd2;

    typedef struct packed {
        logic       busy;
        logic       emit;
        logic       first;
        logic       interior;
        logic       last;
        logic [1:0] mode;
        logic       done;
    } hfs_tag_t;

    function automatic logic signed [TEMP_W-1:0] deg_to_row(
        input logic signed [DEG_W-1:0] t,
        input int                      frac
    );
        logic signed [47:0] w;
        w = 48'(t) <<< frac;
        if (w > 48'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (w < -48'sd2147483648)
            return 32'sh80000000;
        else
            return w[TEMP_W-1:0];
    endfunction

    function automatic logic signed [TEMP_W-1:0] sat_sum(input logic signed [38:0] v);
        if (v > 39'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -39'sd2147483648)
            return 32'sh80000000;
        else
            return v[TEMP_W-1:0];
    endfunction

endpackage

[hdl/heat_equation_ftcs_step.sv]
// top level of the explicit one-dimensional heat-equation stepper
// depends on hfs_pkg, hfs_ram, hfs_seq and hfs_datapath
//
// Each beat on the input either reloads the row (restart = 1), advances it
// one time step, or, once step_count steps are done, re-sends it unchanged; it
// is answered by node_count + 1 output beats, node 0 first, with node_count
// clamped to 2..MAX_NODES. One node is read from the row memory per cycle
// while the output is not stalled; the next beat is taken only after the read
// sweep ends and the pipeline has drained. A final result may still wait in the
// output register while the next item is accepted. Configuration is written
// through cfg_we/cfg_index/cfg_data and must only change while no item is in flight.
module heat_equation_ftcs_step #(
    parameter int MAX_NODES = hfs_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = hfs_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hfs_pkg::NODE_W-1:0]          node_index,
    output logic signed [hfs_pkg::TEMP_W-1:0]   temperature,
    output logic                                last_of_row,
    output logic                                run_done
);

    localparam int AW = $clog2(MAX_NODES + 1);
    localparam int CW = (AW > hfs_pkg::NODE_W) ? AW + 1 : hfs_pkg::NODE_W + 1;

    logic [hfs_pkg::GAIN_W-1:0]        lambda_gain_reg;
    logic signed [hfs_pkg::DEG_W-1:0]  left_temp_reg, right_temp_reg, initial_temp_reg;
    logic [hfs_pkg::NODE_W-1:0]        node_count_reg;
    logic [hfs_pkg::STEP_W-1:0]        step_count_reg;

    logic                       adv, pipe_empty;
    logic                       rd_en, wr_en;
    logic [AW-1:0]              rd_addr, wr_addr;
    logic [hfs_pkg::TEMP_W-1:0] rd_data, wr_data;
    hfs_pkg::hfs_tag_t          tag;
    logic [CW-1:0]              tag_j;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_gain_reg  <= 18'd32768;
            left_temp_reg    <= '0;
            right_temp_reg   <= '0;
            initial_temp_reg <= '0;
            node_count_reg   <= 5'd5;
            step_count_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hfs_pkg::REG_LAMBDA_GAIN:  lambda_gain_reg  <= cfg_data;
                hfs_pkg::REG_LEFT_TEMP:    left_temp_reg    <= cfg_data[hfs_pkg::DEG_W-1:0];
                hfs_pkg::REG_RIGHT_TEMP:   right_temp_reg   <= cfg_data[hfs_pkg::DEG_W-1:0];
                hfs_pkg::REG_INITIAL_TEMP: initial_temp_reg <= cfg_data[hfs_pkg::DEG_W-1:0];
                hfs_pkg::REG_NODE_COUNT:   node_count_reg   <= cfg_data[hfs_pkg::NODE_W-1:0];
                hfs_pkg::REG_STEP_COUNT:   step_count_reg   <= cfg_data[hfs_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    hfs_seq #(
        .MAX_NODES (MAX_NODES),
        .AW        (AW),
        .CW        (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .adv        (adv),
        .pipe_empty (pipe_empty),
        .node_count (node_count_reg),
        .step_count (step_count_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .tag        (tag),
        .tag_j      (tag_j)
    );

    hfs_ram #(
        .WIDTH (hfs_pkg::TEMP_W),
        .DEPTH (MAX_NODES + 1)
    ) u_row_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    hfs_datapath #(
        .MAX_NODES (MAX_NODES),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW),
        .CW        (CW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag          (tag),
        .tag_j        (tag_j),
        .rd_data      (rd_data),
        .lambda_gain  (lambda_gain_reg),
        .left_temp    (left_temp_reg),
        .right_temp   (right_temp_reg),
        .initial_temp (initial_temp_reg),
        .adv          (adv),
        .pipe_empty   (pipe_empty),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .node_index   (node_index),
        .temperature  (temperature),
        .last_of_row  (last_of_row),
        .run_done     (run_done)
    );

endmodule

[hdl/hfs_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module hfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

[hdl/hfs_seq.sv]
// item sequencer: input beat, step counter and per-node read issue
// depends on hfs_pkg
module hfs_seq #(
    parameter int MAX_NODES = hfs_pkg::MAX_NODES_DEF,
    parameter int AW = $clog2(MAX_NODES + 1),
    parameter int CW = (AW > hfs_pkg::NODE_W) ? AW + 1 : hfs_pkg::NODE_W + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        restart,
    input  logic                        adv,
    input  logic                        pipe_empty,
    input  logic [hfs_pkg::NODE_W-1:0]  node_count,
    input  logic [hfs_pkg::STEP_W-1:0]  step_count,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    output hfs_pkg::hfs_tag_t           tag,
    output logic [CW-1:0]               tag_j
);

    logic                       busy_reg, busy_next;
    logic [CW-1:0]              j_reg, j_next;
    logic [CW-1:0]              n_reg, n_next;
    logic [1:0]                 mode_reg, mode_next;
    logic                       done_reg, done_next;
    logic [hfs_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [CW-1:0]              n_clamp;
    logic                       accept;

    assign in_ready = !busy_reg && pipe_empty;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        n_clamp = CW'(node_count);
        if (n_clamp < CW'(2))
            n_clamp = CW'(2);
        else if (n_clamp > CW'(MAX_NODES))
            n_clamp = CW'(MAX_NODES);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        mode_next  = mode_reg;
        done_next  = done_reg;
        steps_next = steps_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            j_next    = '0;
            n_next    = n_clamp;
            if (restart)
            begin
                mode_next  = hfs_pkg::MODE_LOAD;
                steps_next = '0;
                done_next  = (step_count == '0);
            end
            else if (steps_reg < step_count)
            begin
                mode_next  = hfs_pkg::MODE_STEP;
                steps_next = steps_reg + 1'b1;
                done_next  = ((steps_reg + 1'b1) >= step_count);
            end
            else
            begin
                mode_next = hfs_pkg::MODE_HOLD;
                done_next = 1'b1;
            end
        end
        else if (adv && busy_reg)
        begin
            j_next = j_reg + 1'b1;
            if (j_reg == n_reg + 1'b1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            j_reg     <= '0;
            n_reg     <= CW'(2);
            mode_reg  <= hfs_pkg::MODE_HOLD;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            mode_reg  <= mode_next;
            done_reg  <= done_next;
            steps_reg <= steps_next;
        end
    end

    assign rd_en   = adv && busy_reg && (j_reg <= n_reg);
    assign rd_addr = j_reg[AW-1:0];
    assign tag_j   = j_reg;

    always_comb
    begin
        tag.busy     = busy_reg;
        tag.emit     = (j_reg != '0);
        tag.first    = (j_reg == CW'(1));
        tag.interior = (j_reg >= CW'(2)) && (j_reg <= n_reg);
        tag.last     = (j_reg == n_reg + 1'b1);
        tag.mode     = mode_reg;
        tag.done     = done_reg;
    end

endmodule

[hdl/hfs_datapath.sv]
// node update pipeline: neighbour window, second difference, gain multiply,
// rounding, saturation, write-back and output register; depends on hfs_pkg
module hfs_datapath #(
    parameter int MAX_NODES = hfs_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = hfs_pkg::FRAC_BITS_DEF,
    parameter int AW = $clog2(MAX_NODES + 1),
    parameter int CW = (AW > hfs_pkg::NODE_W) ? AW + 1 : hfs_pkg::NODE_W + 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hfs_pkg::hfs_tag_t                  tag,
    input  logic [CW-1:0]                      tag_j,
    input  logic [hfs_pkg::TEMP_W-1:0]         rd_data,
    input  logic [hfs_pkg::GAIN_W-1:0]         lambda_gain,
    input  logic signed [hfs_pkg::DEG_W-1:0]   left_temp,
    input  logic signed [hfs_pkg::DEG_W-1:0]   right_temp,
    input  logic signed [hfs_pkg::DEG_W-1:0]   initial_temp,
    output logic                               adv,
    output logic                               pipe_empty,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output logic [hfs_pkg::TEMP_W-1:0]         wr_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hfs_pkg::NODE_W-1:0]         node_index,
    output logic signed [hfs_pkg::TEMP_W-1:0]  temperature,
    output logic                               last_of_row,
    output logic                               run_done
);

    localparam int DEPTH = MAX_NODES + 1;
    localparam logic signed [53:0] ROUND = 54'sd1 <<< (hfs_pkg::GAIN_FRAC - 1);

    hfs_pkg::hfs_tag_t s1_tag_reg;
    logic [CW-1:0]     s1_j_reg;
    logic [DEPTH-1:0]  vld_reg;

    logic signed [31:0] a_reg, b_reg;

    logic               s2_valid_reg;
    logic [CW-1:0]      s2_i_reg;
    logic               s2_last_reg, s2_done_reg, s2_upd_reg, s2_wr_reg;
    logic signed [33:0] s2_diff_reg;
    logic signed [31:0] s2_base_reg;

    logic               s3_valid_reg;
    logic [CW-1:0]      s3_i_reg;
    logic               s3_last_reg, s3_done_reg, s3_upd_reg, s3_wr_reg;
    logic signed [52:0] s3_prod_reg;
    logic signed [31:0] s3_base_reg;

    logic                              out_valid_reg;
    logic [hfs_pkg::NODE_W-1:0]        node_index_reg;
    logic signed [31:0]                temp_reg;
    logic                              last_reg, done_reg;

    logic [AW-1:0]      s1_addr;
    logic               s1_vbit;
    logic signed [31:0] cur;
    logic signed [33:0] diff;
    logic signed [31:0] load_val, base;
    logic signed [53:0] rnd;
    logic signed [37:0] delta;
    logic signed [38:0] sum;
    logic signed [31:0] new_val;

    assign adv        = !out_valid_reg || out_ready;
    assign pipe_empty = !s1_tag_reg.busy && !s2_valid_reg && !s3_valid_reg;

    // stage 1: old row value arrives, masked for never written entries
    assign s1_addr = s1_j_reg[AW-1:0];
    assign s1_vbit = (s1_addr <= AW'(MAX_NODES)) && vld_reg[s1_addr];
    assign cur     = s1_vbit ? signed'(rd_data) : '0;
    assign diff    = 34'(cur) + 34'(b_reg) - (34'(a_reg) <<< 1);

    always_comb
    begin
        if (s1_tag_reg.first)
            load_val = hfs_pkg::deg_to_row(left_temp, FRAC_BITS);
        else if (s1_tag_reg.last)
            load_val = hfs_pkg::deg_to_row(right_temp, FRAC_BITS);
        else
            load_val = hfs_pkg::deg_to_row(initial_temp, FRAC_BITS);
        base = (s1_tag_reg.mode == hfs_pkg::MODE_LOAD) ? load_val : a_reg;
    end

    // last stage: round, add, saturate
    assign rnd     = 54'(s3_prod_reg) + ROUND;
    assign delta   = 38'(rnd >>> hfs_pkg::GAIN_FRAC);
    assign sum     = 39'(s3_base_reg) + 39'(delta);
    assign new_val = s3_upd_reg ? hfs_pkg::sat_sum(sum) : s3_base_reg;

    assign wr_en   = adv && s3_valid_reg && s3_wr_reg;
    assign wr_addr = s3_i_reg[AW-1:0];
    assign wr_data = new_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg    <= '0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_tag_reg    <= tag;
                s2_valid_reg  <= s1_tag_reg.busy && s1_tag_reg.emit;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_j_reg <= tag_j;
            a_reg    <= cur;
            b_reg    <= a_reg;

            s2_i_reg    <= s1_j_reg - 1'b1;
            s2_last_reg <= s1_tag_reg.last;
            s2_done_reg <= s1_tag_reg.done;
            s2_upd_reg  <= (s1_tag_reg.mode == hfs_pkg::MODE_STEP) && s1_tag_reg.interior;
            s2_wr_reg   <= (s1_tag_reg.mode != hfs_pkg::MODE_HOLD);
            s2_diff_reg <= diff;
            s2_base_reg <= base;

            s3_i_reg    <= s2_i_reg;
            s3_last_reg <= s2_last_reg;
            s3_done_reg <= s2_done_reg;
            s3_upd_reg  <= s2_upd_reg;
            s3_wr_reg   <= s2_wr_reg;
            s3_prod_reg <= 53'(s2_diff_reg) * 53'($signed({1'b0, lambda_gain}));
            s3_base_reg <= s2_base_reg;

            node_index_reg <= s3_i_reg[hfs_pkg::NODE_W-1:0];
            temp_reg       <= new_val;
            last_reg       <= s3_last_reg;
            done_reg       <= s3_done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign node_index  = node_index_reg;
    assign temperature = temp_reg;
    assign last_of_row = last_reg;
    assign run_done    = done_reg;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// self-checking bench for heat_equation_ftcs_step: predicts every node beat of each row
// from its own copy of the row and the registers; depends on hfs_pkg and the stepper rtl
module tb_top;

    localparam logic [hfs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [hfs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [hfs_pkg::NODE_W-1:0]        idx;
        logic signed [hfs_pkg::TEMP_W-1:0] temp;
        logic                              tail;
        logic                              done;
    } node_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [hfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic restart = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [hfs_pkg::NODE_W-1:0] node_index;
    logic signed [hfs_pkg::TEMP_W-1:0] temperature;
    logic last_of_row;
    logic run_done;

    // register copies and row state of the predictor
    logic [hfs_pkg::GAIN_W-1:0] gain_q = 18'd32768;
    logic [hfs_pkg::DEG_W-1:0] left_deg = '0;
    logic [hfs_pkg::DEG_W-1:0] right_deg = '0;
    logic [hfs_pkg::DEG_W-1:0] initial_deg = '0;
    logic [hfs_pkg::NODE_W-1:0] nodes_q = 5'd5;
    logic [hfs_pkg::STEP_W-1:0] steps_goal = '0;
    logic [hfs_pkg::STEP_W-1:0] steps_done = '0;
    logic signed [hfs_pkg::TEMP_W-1:0] row_q [0:hfs_pkg::MAX_NODES_DEF] = '{default: '0};

    node_beat_t node_beats_due [$];
    int mismatches = 0;
    int beats_sent = 0;
    int send_idle_pct = 35;
    int recv_idle_pct = 48;

    heat_equation_ftcs_step uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .node_index  (node_index),
        .temperature (temperature),
        .last_of_row (last_of_row),
        .run_done    (run_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic signed [hfs_pkg::TEMP_W-1:0] clip32(input longint v);
        if (v > longint'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        else if (v < -longint'(64'sd2147483648))
            return 32'sh80000000;
        else
            return v[hfs_pkg::TEMP_W-1:0];
    endfunction

    function automatic logic signed [hfs_pkg::TEMP_W-1:0] deg_row(
        input logic [hfs_pkg::DEG_W-1:0] d
    );
        return clip32(longint'($signed(d)) <<< hfs_pkg::FRAC_BITS_DEF);
    endfunction

    // one ftcs update, reload or unchanged hold, then queue the whole row
    function automatic void ftcs_predict(input logic rs);
        logic signed [hfs_pkg::TEMP_W-1:0] prev [0:hfs_pkg::MAX_NODES_DEF];
        int last_node;
        longint diff;
        longint delta;
        node_beat_t b;
        last_node = (nodes_q < 2) ? 2 :
                    ((nodes_q > hfs_pkg::MAX_NODES_DEF) ? hfs_pkg::MAX_NODES_DEF : nodes_q);
        if (rs)
        begin
            steps_done = '0;
            row_q[0] = deg_row(left_deg);
            for (int i = 1; i < last_node; i++)
                row_q[i] = deg_row(initial_deg);
            row_q[last_node] = deg_row(right_deg);
        end
        else if (steps_done < steps_goal)
        begin
            prev = row_q;
            for (int i = 1; i < last_node; i++)
            begin
                diff = longint'(prev[i+1]) - 2 * longint'(prev[i]) + longint'(prev[i-1]);
                delta = (diff * longint'(gain_q) + (longint'(1) <<< (hfs_pkg::GAIN_FRAC - 1)))
                        >>> hfs_pkg::GAIN_FRAC;
                row_q[i] = clip32(longint'(prev[i]) + delta);
            end
            steps_done = steps_done + 1'b1;
        end
        for (int i = 0; i <= last_node; i++)
        begin
            b.idx = i[hfs_pkg::NODE_W-1:0];
            b.temp = row_q[i];
            b.tail = (i == last_node);
            b.done = (steps_done >= steps_goal);
            node_beats_due.push_back(b);
        end
    endfunction

    always @(posedge clk)
    begin
        node_beat_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (node_beats_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat node %0d temperature %0d", $time,
                         node_index, temperature);
            end
            else
            begin
                due = node_beats_due.pop_front();
                if (node_index !== due.idx)
                begin
                    mismatches++;
                    $display("%0t: node_index expected %0d got %0d", $time,
                             due.idx, node_index);
                end
                if (temperature !== due.temp)
                begin
                    mismatches++;
                    $display("%0t: node %0d temperature expected %0d got %0d", $time,
                             due.idx, due.temp, temperature);
                end
                if (last_of_row !== due.tail)
                begin
                    mismatches++;
                    $display("%0t: node %0d last_of_row expected %0b got %0b", $time,
                             due.idx, due.tail, last_of_row);
                end
                if (run_done !== due.done)
                begin
                    mismatches++;
                    $display("%0t: node %0d run_done expected %0b got %0b", $time,
                             due.idx, due.done, run_done);
                end
            end
        end
    end

    task automatic write_reg(input logic [hfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hfs_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            hfs_pkg::REG_LAMBDA_GAIN:  gain_q = val[hfs_pkg::GAIN_W-1:0];
            hfs_pkg::REG_LEFT_TEMP:    left_deg = val[hfs_pkg::DEG_W-1:0];
            hfs_pkg::REG_RIGHT_TEMP:   right_deg = val[hfs_pkg::DEG_W-1:0];
            hfs_pkg::REG_INITIAL_TEMP: initial_deg = val[hfs_pkg::DEG_W-1:0];
            hfs_pkg::REG_NODE_COUNT:   nodes_q = val[hfs_pkg::NODE_W-1:0];
            hfs_pkg::REG_STEP_COUNT:   steps_goal = val[hfs_pkg::STEP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_beat(input logic rs);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        restart <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        ftcs_predict(rs);
    endtask

    task automatic drain_row_beats();
        in_valid <= 1'b0;
        while (node_beats_due.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic test_power_up_row();
        send_beat(1'b0);
        drain_row_beats();
    endtask

    task automatic test_extremes();
        write_reg(hfs_pkg::REG_LAMBDA_GAIN, 18'h3FFFF);
        write_reg(hfs_pkg::REG_LEFT_TEMP, 18'h08000);
        write_reg(hfs_pkg::REG_RIGHT_TEMP, 18'h07FFF);
        write_reg(hfs_pkg::REG_INITIAL_TEMP, 18'h07FFF);
        write_reg(hfs_pkg::REG_NODE_COUNT, 18'd16);
        write_reg(hfs_pkg::REG_STEP_COUNT, 18'd3);
        send_beat(1'b1);
        repeat (4) send_beat(1'b0);
        drain_row_beats();
        write_reg(hfs_pkg::REG_LAMBDA_GAIN, 18'd0);
        write_reg(hfs_pkg::REG_INITIAL_TEMP, 18'h08000);
        write_reg(hfs_pkg::REG_STEP_COUNT, 18'hFFFF);
        send_beat(1'b1);
        send_beat(1'b0);
        drain_row_beats();
    endtask

    task automatic test_node_clamp();
        int clamp_vals [4] = '{0, 1, 17, 31};
        write_reg(hfs_pkg::REG_LAMBDA_GAIN, 18'd32768);
        foreach (clamp_vals[k])
        begin
            write_reg(hfs_pkg::REG_NODE_COUNT, 18'(clamp_vals[k]));
            send_beat(1'b1);
            send_beat(1'b0);
            drain_row_beats();
        end
    endtask

    task automatic test_resize_after_load();
        write_reg(hfs_pkg::REG_INITIAL_TEMP, 18'd100);
        write_reg(hfs_pkg::REG_NODE_COUNT, 18'd16);
        send_beat(1'b1);
        drain_row_beats();
        write_reg(hfs_pkg::REG_NODE_COUNT, 18'd3);
        send_beat(1'b0);
        drain_row_beats();
        write_reg(hfs_pkg::REG_NODE_COUNT, 18'd16);
        send_beat(1'b0);
        drain_row_beats();
    endtask

    task automatic test_spare_index();
        write_reg(REG_SPARE_LO, 18'h3FFFF);
        write_reg(REG_SPARE_HI, 18'h3FFFF);
        send_beat(1'b1);
        send_beat(1'b0);
        drain_row_beats();
    endtask

    function automatic logic [hfs_pkg::CFG_DATA_W-1:0] pick_deg();
        if ($urandom_range(1))
            return 18'($urandom_range(65535));
        else
            return 18'(16'($urandom_range(400) - 200));
    endfunction

    task automatic test_random_runs(input int s_pct, input int r_pct, input int beats);
        int target;
        int steps_in_run;
        target = beats_sent + beats;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        while (beats_sent < target)
        begin
            drain_row_beats();
            if ($urandom_range(1))
            begin
                case ($urandom_range(3))
                    0: write_reg(hfs_pkg::REG_LAMBDA_GAIN, 18'($urandom_range(32768)));
                    1: write_reg(hfs_pkg::REG_LAMBDA_GAIN, 18'($urandom_range(65535)));
                    2: write_reg(hfs_pkg::REG_LAMBDA_GAIN, 18'($urandom_range(262143)));
                    default: write_reg(hfs_pkg::REG_LAMBDA_GAIN, 18'($urandom_range(8192)));
                endcase
            end
            if ($urandom_range(1))
                write_reg(hfs_pkg::REG_LEFT_TEMP, pick_deg());
            if ($urandom_range(1))
                write_reg(hfs_pkg::REG_RIGHT_TEMP, pick_deg());
            if ($urandom_range(1))
                write_reg(hfs_pkg::REG_INITIAL_TEMP, pick_deg());
            if ($urandom_range(2) == 0)
                write_reg(hfs_pkg::REG_NODE_COUNT, 18'($urandom_range(4) == 0 ?
                                              $urandom_range(31) : $urandom_range(2, 16)));
            if ($urandom_range(1))
                write_reg(hfs_pkg::REG_STEP_COUNT, 18'($urandom_range(9) == 0 ?
                                              $urandom_range(65535) : $urandom_range(10)));
            // mostly clean runs, now and then a run without a fresh load
            if ($urandom_range(9) != 0)
                send_beat(1'b1);
            steps_in_run = $urandom_range((steps_goal > 10) ? 12 : steps_goal + 2);
            for (int k = 0; k < steps_in_run; k++)
                send_beat($urandom_range(19) == 0);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_up_row();
        test_extremes();
        test_node_clamp();
        test_resize_after_load();
        test_spare_index();
        test_random_runs(35, 48, 130);
        test_random_runs(48, 35, 130);
        test_random_runs(0, 0, 130);
        drain_row_beats();
        if (mismatches == 0 && node_beats_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
